/* sv/base64_stream_encoder_assert.svh */
// Assertion macros for the base64 stream encoder checker.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication
`define B64_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// next-cycle implication
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

/* sv/b64enc_pkg.sv */
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
package b64enc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // one finished group: bytes left-aligned, number of real bytes (1..3)
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        fin;
  } group_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

/* sv/b64enc_fifo.sv */
// Short group queue between the byte front end and the character back end.
// Depends on b64enc_pkg.
module b64enc_fifo #(
  parameter int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64enc_pkg::group_t  push_data,
  input  logic                pop,
  output b64enc_pkg::group_t  pop_data,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64enc_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/b64enc_front.sv */
// Front end: gathers bytes into three-byte groups and hands finished groups on.
// Depends on b64enc_pkg.
module b64enc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               final_byte,
  output logic               push,
  output b64enc_pkg::group_t entry
);

  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] group_count;

  always_comb begin
    entry.fin = final_byte;
    unique case (group_count)
      2'd1: begin
        entry.word   = {held_first, data_byte, 8'h00};
        entry.nbytes = 2'd2;
        push         = accept && final_byte;
      end
      2'd2: begin
        entry.word   = {held_first, held_second, data_byte};
        entry.nbytes = 2'd3;
        push         = accept;
      end
      2'd0, 2'd3: begin
        entry.word   = {data_byte, 16'h0000};
        entry.nbytes = 2'd1;
        push         = accept && final_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first  <= '0;
      held_second <= '0;
      group_count <= '0;
    end else if (accept) begin
      if (push) begin
        held_first  <= '0;
        held_second <= '0;
        group_count <= '0;
      end else if (group_count == 2'd1) begin
        held_second <= data_byte;
        group_count <= 2'd2;
      end else begin
        held_first  <= data_byte;
        group_count <= 2'd1;
      end
    end
  end

endmodule

/* sv/b64enc_back.sv */
// Back end: turns one queued group into four characters on the output register.
// Depends on b64enc_pkg.
module b64enc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  b64enc_pkg::group_t entry,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  logic               busy;
  logic [1:0]         idx;
  b64enc_pkg::group_t cur;
  logic               adv;
  logic [5:0]         sext;
  logic [7:0]         ch;

  assign adv = busy && (!m_tvalid || m_tready);
  assign pop = !empty && (!busy || (adv && idx == 2'd3));

  always_comb begin
    unique case (idx)
      2'd0: sext = cur.word[23:18];
      2'd1: sext = cur.word[17:12];
      2'd2: sext = cur.word[11:6];
      2'd3: sext = cur.word[5:0];
    endcase
    ch = (idx > cur.nbytes) ? b64enc_pkg::PAD_CHAR : b64enc_pkg::enc_char(sext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
        m_tdata  <= ch;
        m_tlast  <= (idx == 2'd3);
        m_tuser  <= (idx == 2'd3) && cur.fin;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        cur  <= entry;
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        idx <= idx + 1'b1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/base64_stream_encoder.sv */
// Base64 (standard alphabet, '=' padded) stream encoder, one byte per request in.
// A finished group goes into the group queue, then the back end's current group, then the output register.
// Throughput: one byte per cycle in while the group queue is not full, one character per cycle out
// while m_tready is high; sustained rate is set by the single-character output register.
// Reset (rst, synchronous) empties the group queue and clears pending bytes.
// Depends on b64enc_pkg, b64enc_front, b64enc_fifo, b64enc_back.
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // run_last
  output logic [0:0] m_tuser    // [0] message_end
);

  b64enc_pkg::group_t push_entry;
  b64enc_pkg::group_t pop_entry;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic msg_end;

  assign s_tready   = !full;
  assign m_tuser[0] = msg_end;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_tvalid && s_tready),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .push       (push),
    .entry      (push_entry)
  );

  b64enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .full      (full),
    .empty     (empty)
  );

  b64enc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .entry    (pop_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (msg_end)
  );

endmodule

/* sv/b64enc_checker.sv */
// Port-level checks for base64_stream_encoder, attached by bind.
// Depends on b64enc_pkg and base64_stream_encoder_assert.svh.
`include "base64_stream_encoder_assert.svh"

module b64enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [0:0] m_tuser
);

  logic is_pad;
  logic is_b64;

  assign is_pad = (m_tdata == b64enc_pkg::PAD_CHAR);
  assign is_b64 = (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                  (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                  (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                  m_tdata == 8'h2B || m_tdata == 8'h2F;

  `B64_ASSERT_NOW(end_on_run_last, m_tvalid && m_tuser[0], m_tlast)
  `B64_ASSERT_NEXT(pad_runs_to_end, m_tvalid && m_tready && !m_tlast && is_pad, !m_tvalid || is_pad)
  `B64_ASSERT_NOW(no_pad_mid_message, m_tvalid && m_tlast && !m_tuser[0], !is_pad)
  `B64_ASSERT_NOW(legal_char, m_tvalid, is_b64 || is_pad)
  `B64_ASSERT_NEXT(out_held_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind base64_stream_encoder b64enc_checker u_checker (.*);
